// ===== sv/scbp_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers for the sparse csc block partition core
// no dependencies

package scbp_pkg;

  localparam int MAX_BLOCKS    = 4;
  localparam int MAX_BLOCK_DIM = 64;
  localparam int TILE_CAPACITY = 1024;

  localparam int NTILES        = MAX_BLOCKS * MAX_BLOCKS;
  localparam int PTRS_PER_TILE = MAX_BLOCK_DIM + 1;
  localparam int CC_DEPTH      = NTILES * PTRS_PER_TILE;
  localparam int CC_AW         = $clog2(CC_DEPTH);
  localparam int RS_DEPTH      = NTILES * TILE_CAPACITY;
  localparam int RS_AW         = $clog2(RS_DEPTH);
  localparam int TILE_W        = $clog2(NTILES);
  localparam int CNT_W         = $clog2(TILE_CAPACITY + 1);

  localparam int MODE_W     = 2;
  localparam int COORD_W    = 8;
  localparam int BSEL_W     = 2;
  localparam int LCOL_W     = 7;
  localparam int SLOT_W     = 10;
  localparam int LROW_W     = 6;
  localparam int PTR_W      = 11;
  localparam int STAT_W     = 2;
  localparam int NB_W       = 3;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [NB_W-1:0]  NB_RESET  = NB_W'(4);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  localparam logic [MODE_W-1:0] MODE_ENTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PTR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINAL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ROW   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FINAL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DIM  = 2'd1;

  typedef struct packed {
    logic              done;
    logic [BSEL_W-1:0] tr;
    logic [BSEL_W-1:0] tc;
    logic [LROW_W-1:0] lr;
    logic [LROW_W-1:0] lc;
  } scbp_div_res_t;

  typedef struct packed {
    logic [BSEL_W-1:0] tile_row;
    logic [BSEL_W-1:0] tile_col;
    logic [LROW_W-1:0] local_row;
    logic [SLOT_W-1:0] slot;
    logic [PTR_W-1:0]  pointer;
    logic [STAT_W-1:0] status;
  } scbp_res_t;

  function automatic logic [NB_W-1:0] eff_blocks(input logic [NB_W-1:0] v);
    logic [NB_W-1:0] r;
    if (v == NB_W'(0)) r = NB_W'(1);
    else if (v > NB_W'(MAX_BLOCKS)) r = NB_W'(MAX_BLOCKS);
    else r = v;
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == DIM_W'(0)) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_BLOCK_DIM)) r = DIM_W'(MAX_BLOCK_DIM);
    else r = v;
    return r;
  endfunction

  function automatic scbp_res_t mk_res(input logic [BSEL_W-1:0] tr,
                                       input logic [BSEL_W-1:0] tc,
                                       input logic [LROW_W-1:0] lr,
                                       input logic [SLOT_W-1:0] sl,
                                       input logic [PTR_W-1:0]  ptr,
                                       input logic [STAT_W-1:0] st);
    scbp_res_t r;
    r.tile_row  = tr;
    r.tile_col  = tc;
    r.local_row = lr;
    r.slot      = sl;
    r.pointer   = ptr;
    r.status    = st;
    return r;
  endfunction

endpackage

// ===== sv/scbp_ifs.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces: input items, results, register writes
// depends on scbp_pkg

interface scbp_in_if;
  import scbp_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  col;
  logic [BSEL_W-1:0]   sel_block_row;
  logic [BSEL_W-1:0]   sel_block_col;
  logic [LCOL_W-1:0]   sel_local_col;
  logic [SLOT_W-1:0]   sel_slot;
  modport source (output valid, mode, row, col, sel_block_row, sel_block_col,
                  sel_local_col, sel_slot, input ready);
  modport sink (input valid, mode, row, col, sel_block_row, sel_block_col,
                sel_local_col, sel_slot, output ready);
endinterface

interface scbp_out_if;
  import scbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BSEL_W-1:0] tile_row;
  logic [BSEL_W-1:0] tile_col;
  logic [LROW_W-1:0] local_row;
  logic [SLOT_W-1:0] slot;
  logic [PTR_W-1:0]  pointer;
  logic [STAT_W-1:0] status;
  modport source (output valid, tile_row, tile_col, local_row, slot, pointer, status,
                  input ready);
  modport sink (input valid, tile_row, tile_col, local_row, slot, pointer, status,
                output ready);
endinterface

interface scbp_cfg_if;
  import scbp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/scbp_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read port
// no dependencies

module scbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/scbp_tile_div.sv =====
`timescale 1ns / 1ps
// iterative tile index divider: row and col by block_dim, one subtract per cycle
// depends on scbp_pkg

module scbp_tile_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [scbp_pkg::COORD_W-1:0]  row,
  input  logic [scbp_pkg::COORD_W-1:0]  col,
  input  logic [scbp_pkg::DIM_W-1:0]    dim,
  output scbp_pkg::scbp_div_res_t       res
);
  import scbp_pkg::*;

  logic               busy_r;
  logic [COORD_W-1:0] rrow_r;
  logic [COORD_W-1:0] rcol_r;
  logic [BSEL_W-1:0]  qrow_r;
  logic [BSEL_W-1:0]  qcol_r;
  logic [COORD_W-1:0] dim_ext;
  logic               row_ge;
  logic               col_ge;

  assign dim_ext = COORD_W'(dim);
  assign row_ge  = rrow_r >= dim_ext;
  assign col_ge  = rcol_r >= dim_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      rrow_r <= row;
      rcol_r <= col;
      qrow_r <= '0;
      qcol_r <= '0;
    end else if (busy_r) begin
      if (row_ge) begin
        rrow_r <= rrow_r - dim_ext;
        qrow_r <= qrow_r + BSEL_W'(1);
      end
      if (col_ge) begin
        rcol_r <= rcol_r - dim_ext;
        qcol_r <= qcol_r + BSEL_W'(1);
      end
      if (!row_ge && !col_ge) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign res.done = busy_r && !row_ge && !col_ge;
  assign res.tr   = qrow_r;
  assign res.tc   = qcol_r;
  assign res.lr   = rrow_r[LROW_W-1:0];
  assign res.lc   = rcol_r[LROW_W-1:0];

endmodule

// ===== sv/sparse_csc_block_partition_core.sv =====
`timescale 1ns / 1ps
// sparse csc block partition core: tiles nonzeros, builds per-tile column pointers
// depends on scbp_pkg, scbp_ifs, scbp_ram, scbp_tile_div
//
// port     dir  handshake    payload
// in_ch    in   valid/ready  mode row col sel_block_row sel_block_col sel_local_col sel_slot
// out_ch   out  valid/ready  tile_row tile_col local_row slot pointer status
// cfg_ch   in   valid/ready  index data, always ready
//
// enter goes through check, iterative divide steps, count ram read-modify-write
// reads go through one count or row ram read; finalize walks every tile
// through the single read port of the count ram
// after reset a pass over all 1040 count ram words clears it, input is not ready meanwhile
// a held result sits in the output register while the next transfer is taken

module sparse_csc_block_partition_core (
  input logic        clk,
  input logic        rst_n,
  scbp_in_if.sink    in_ch,
  scbp_out_if.source out_ch,
  scbp_cfg_if.sink   cfg_ch
);
  import scbp_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHK, ST_DIV, ST_ENT_RD, ST_ENT_WR,
    ST_FIN_RD, ST_FIN_WR, ST_FIN_LAST, ST_RD_WAIT, ST_DONE
  } state_t;

  state_t             state_r;
  logic [NB_W-1:0]    nb_r;
  logic [DIM_W-1:0]   dim_r;
  logic [NB_W-1:0]    nb_eff;
  logic [DIM_W-1:0]   dim_eff;

  logic [MODE_W-1:0]  mode_r;
  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] col_r;
  logic [BSEL_W-1:0]  br_r;
  logic [BSEL_W-1:0]  bc_r;
  logic [LCOL_W-1:0]  lcsel_r;
  logic [SLOT_W-1:0]  slsel_r;

  logic [BSEL_W-1:0]  tr_r;
  logic [BSEL_W-1:0]  tc_r;
  logic [LROW_W-1:0]  lr_r;
  logic [LROW_W-1:0]  lc_r;

  logic               fin_r;
  logic [CNT_W-1:0]   fill_r [NTILES];
  logic [CC_AW-1:0]   clr_r;
  logic [TILE_W-1:0]  tf_r;
  logic [DIM_W-1:0]   j_r;
  logic [PTR_W-1:0]   acc_r;

  scbp_res_t          res_r;
  scbp_res_t          out_r;
  logic               out_valid_r;
  logic               out_load;

  logic [NB_W+DIM_W-1:0] n_lim;
  logic               row_out;
  logic               col_out;
  logic [TILE_W-1:0]  t_sel;
  logic [TILE_W-1:0]  t_ent;
  logic [TILE_W-1:0]  fill_idx;
  logic [CNT_W-1:0]   fill_rd;
  logic               tile_ok;
  logic               ptr_ok;
  logic               row_ok;
  logic               tile_full;
  logic               div_start;
  scbp_div_res_t      div_res;

  logic [CC_AW-1:0]   base_sel;
  logic [CC_AW-1:0]   base_ent;
  logic [CC_AW-1:0]   base_fin;
  logic               cc_we;
  logic [CC_AW-1:0]   cc_waddr;
  logic [PTR_W-1:0]   cc_wdata;
  logic [CC_AW-1:0]   cc_raddr;
  logic [PTR_W-1:0]   cc_rdata;
  logic [PTR_W-1:0]   acc_sum;
  logic [DIM_W-1:0]   j_inc;

  logic               rs_we;
  logic [RS_AW-1:0]   rs_waddr;
  logic [RS_AW-1:0]   rs_raddr;
  logic [LROW_W-1:0]  rs_rdata;

  assign nb_eff  = eff_blocks(nb_r);
  assign dim_eff = eff_dim(dim_r);
  assign n_lim   = (NB_W+DIM_W)'((NB_W+DIM_W)'(nb_eff) * (NB_W+DIM_W)'(dim_eff));
  assign row_out = (NB_W+DIM_W)'(row_r) >= n_lim;
  assign col_out = (NB_W+DIM_W)'(col_r) >= n_lim;

  assign t_sel = TILE_W'(TILE_W'(br_r) * TILE_W'(MAX_BLOCKS) + TILE_W'(bc_r));
  assign t_ent = TILE_W'(TILE_W'(tr_r) * TILE_W'(MAX_BLOCKS) + TILE_W'(tc_r));

  always_comb begin
    case (state_r)
      ST_CHK:    fill_idx = t_sel;
      ST_ENT_RD: fill_idx = t_ent;
      default:   fill_idx = tf_r;
    endcase
  end

  assign fill_rd   = fill_r[fill_idx];
  assign tile_ok   = (NB_W'(br_r) < nb_eff) && (NB_W'(bc_r) < nb_eff);
  assign ptr_ok    = tile_ok && (lcsel_r <= dim_eff);
  assign row_ok    = tile_ok && (CNT_W'(slsel_r) < fill_rd);
  assign tile_full = fill_rd >= CNT_W'(TILE_CAPACITY);
  assign div_start = (state_r == ST_CHK) && (mode_r == MODE_ENTER) && !fin_r &&
                     !row_out && !col_out;

  scbp_tile_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .row   (row_r),
    .col   (col_r),
    .dim   (dim_eff),
    .res   (div_res)
  );

  // column count ram
  assign base_sel = CC_AW'(CC_AW'(t_sel) * CC_AW'(PTRS_PER_TILE));
  assign base_ent = CC_AW'(CC_AW'(t_ent) * CC_AW'(PTRS_PER_TILE));
  assign base_fin = CC_AW'(CC_AW'(tf_r) * CC_AW'(PTRS_PER_TILE));
  assign acc_sum  = acc_r + cc_rdata;
  assign j_inc    = j_r + DIM_W'(1);

  always_comb begin
    case (state_r)
      ST_CHK:    cc_raddr = base_sel + CC_AW'(lcsel_r);
      ST_ENT_RD: cc_raddr = base_ent + CC_AW'(lc_r) + CC_AW'(1);
      default:   cc_raddr = base_fin + CC_AW'(j_r);
    endcase
  end

  always_comb begin
    cc_we    = 1'b0;
    cc_waddr = base_fin + CC_AW'(j_r);
    cc_wdata = acc_sum;
    case (state_r)
      ST_CLEAR: begin
        cc_we    = 1'b1;
        cc_waddr = clr_r;
        cc_wdata = '0;
      end
      ST_ENT_WR: begin
        cc_we    = 1'b1;
        cc_waddr = base_ent + CC_AW'(lc_r) + CC_AW'(1);
        cc_wdata = cc_rdata + PTR_W'(1);
      end
      ST_FIN_WR: begin
        cc_we = 1'b1;
      end
      ST_FIN_LAST: begin
        cc_we    = 1'b1;
        cc_waddr = base_fin + CC_AW'(dim_eff);
        cc_wdata = PTR_W'(fill_rd);
      end
      default: begin
        cc_we = 1'b0;
      end
    endcase
  end

  scbp_ram #(.WIDTH(PTR_W), .DEPTH(CC_DEPTH)) u_cc_ram (
    .clk   (clk),
    .we    (cc_we),
    .waddr (cc_waddr),
    .wdata (cc_wdata),
    .raddr (cc_raddr),
    .rdata (cc_rdata)
  );

  // stored local rows
  assign rs_we    = (state_r == ST_ENT_RD) && !tile_full;
  assign rs_waddr = RS_AW'(RS_AW'(t_ent) * RS_AW'(TILE_CAPACITY)) +
                    RS_AW'(fill_rd[SLOT_W-1:0]);
  assign rs_raddr = RS_AW'(RS_AW'(t_sel) * RS_AW'(TILE_CAPACITY)) + RS_AW'(slsel_r);

  scbp_ram #(.WIDTH(LROW_W), .DEPTH(RS_DEPTH)) u_rs_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (lr_r),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  assign out_load        = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.tile_row = out_r.tile_row;
  assign out_ch.tile_col = out_r.tile_col;
  assign out_ch.local_row = out_r.local_row;
  assign out_ch.slot     = out_r.slot;
  assign out_ch.pointer  = out_r.pointer;
  assign out_ch.status   = out_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      nb_r        <= NB_RESET;
      dim_r       <= DIM_RESET;
      tf_r        <= '0;
      j_r         <= DIM_W'(1);
      acc_r       <= '0;
      for (int i = 0; i < NTILES; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_NUM_BLOCKS: nb_r <= cfg_ch.data[NB_W-1:0];
          CFG_BLOCK_DIM:  dim_r <= cfg_ch.data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_r       <= res_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + CC_AW'(1);
          if (clr_r == CC_AW'(CC_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            mode_r  <= in_ch.mode;
            row_r   <= in_ch.row;
            col_r   <= in_ch.col;
            br_r    <= in_ch.sel_block_row;
            bc_r    <= in_ch.sel_block_col;
            lcsel_r <= in_ch.sel_local_col;
            slsel_r <= in_ch.sel_slot;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          case (mode_r)
            MODE_ENTER: begin
              if (fin_r) begin
                res_r   <= mk_res('0, '0, '0, '0, '0, STAT_FINAL);
                state_r <= ST_DONE;
              end else if (row_out || col_out) begin
                res_r   <= mk_res('0, '0, '0, '0, '0, STAT_RANGE);
                state_r <= ST_DONE;
              end else begin
                state_r <= ST_DIV;
              end
            end
            MODE_FINAL: begin
              if (fin_r) begin
                res_r   <= mk_res('0, '0, '0, '0, '0, STAT_FINAL);
                state_r <= ST_DONE;
              end else begin
                tf_r    <= '0;
                j_r     <= DIM_W'(1);
                acc_r   <= '0;
                state_r <= (dim_eff == DIM_W'(1)) ? ST_FIN_LAST : ST_FIN_RD;
              end
            end
            MODE_PTR: begin
              if (ptr_ok) begin
                state_r <= ST_RD_WAIT;
              end else begin
                res_r   <= mk_res(br_r, bc_r, '0, '0, '0, STAT_RANGE);
                state_r <= ST_DONE;
              end
            end
            default: begin
              if (row_ok) begin
                state_r <= ST_RD_WAIT;
              end else begin
                res_r   <= mk_res(br_r, bc_r, '0, slsel_r, '0, STAT_RANGE);
                state_r <= ST_DONE;
              end
            end
          endcase
        end
        ST_DIV: begin
          if (div_res.done) begin
            tr_r    <= div_res.tr;
            tc_r    <= div_res.tc;
            lr_r    <= div_res.lr;
            lc_r    <= div_res.lc;
            state_r <= ST_ENT_RD;
          end
        end
        ST_ENT_RD: begin
          if (tile_full) begin
            res_r   <= mk_res(tr_r, tc_r, lr_r, '0, '0, STAT_FULL);
            state_r <= ST_DONE;
          end else begin
            fill_r[t_ent] <= fill_rd + CNT_W'(1);
            res_r   <= mk_res(tr_r, tc_r, lr_r, fill_rd[SLOT_W-1:0], '0, STAT_OK);
            state_r <= ST_ENT_WR;
          end
        end
        ST_ENT_WR: begin
          state_r <= ST_DONE;
        end
        ST_FIN_RD: begin
          state_r <= ST_FIN_WR;
        end
        ST_FIN_WR: begin
          acc_r   <= acc_sum;
          j_r     <= j_inc;
          state_r <= (j_inc == dim_eff) ? ST_FIN_LAST : ST_FIN_RD;
        end
        ST_FIN_LAST: begin
          if (tf_r == TILE_W'(NTILES - 1)) begin
            fin_r   <= 1'b1;
            res_r   <= mk_res('0, '0, '0, '0, '0, STAT_OK);
            state_r <= ST_DONE;
          end else begin
            tf_r    <= tf_r + TILE_W'(1);
            j_r     <= DIM_W'(1);
            acc_r   <= '0;
            state_r <= (dim_eff == DIM_W'(1)) ? ST_FIN_LAST : ST_FIN_RD;
          end
        end
        ST_RD_WAIT: begin
          if (mode_r == MODE_PTR) begin
            res_r <= mk_res(br_r, bc_r, '0, '0, cc_rdata, STAT_OK);
          end else begin
            res_r <= mk_res(br_r, bc_r, rs_rdata, slsel_r, '0, STAT_OK);
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for sparse_csc_block_partition_core: directed and random items, tile predictor
// depends on scbp_pkg, scbp_ifs and the core rtl

module tb;
  import scbp_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [BSEL_W-1:0]  sel_block_row;
    logic [BSEL_W-1:0]  sel_block_col;
    logic [LCOL_W-1:0]  sel_local_col;
    logic [SLOT_W-1:0]  sel_slot;
  } item_t;

  class csc_tile_tracker;
    logic [NB_W-1:0]   nb_reg;
    logic [DIM_W-1:0]  dim_reg;
    logic [PTR_W-1:0]  col_count [NTILES][PTRS_PER_TILE];
    logic [PTR_W-1:0]  fill [NTILES];
    logic [LROW_W-1:0] row_mem [NTILES][TILE_CAPACITY];
    bit                done_final;
    scbp_res_t         pending_results [$];
    int                bad_results;

    function new();
      nb_reg = NB_RESET;
      dim_reg = DIM_RESET;
      done_final = 1'b0;
      bad_results = 0;
      for (int t = 0; t < NTILES; t++) begin
        fill[t] = '0;
        for (int j = 0; j < PTRS_PER_TILE; j++) col_count[t][j] = '0;
      end
    endfunction

    function int unsigned blocks();
      if (nb_reg == 0) return 1;
      if (nb_reg > MAX_BLOCKS) return MAX_BLOCKS;
      return nb_reg;
    endfunction

    function int unsigned dim();
      if (dim_reg == 0) return 1;
      if (dim_reg > MAX_BLOCK_DIM) return MAX_BLOCK_DIM;
      return dim_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_NUM_BLOCKS) nb_reg = val[NB_W-1:0];
      else if (idx == CFG_BLOCK_DIM) dim_reg = val[DIM_W-1:0];
    endfunction

    function scbp_res_t tile_outcome(item_t it);
      scbp_res_t r;
      int unsigned nb, d, n, tr, tc, lr, lc, t, s;
      r = '0;
      nb = blocks();
      d = dim();
      case (it.mode)
        MODE_ENTER: begin
          n = nb * d;
          if (done_final) r.status = STAT_FINAL;
          else if (it.row >= n || it.col >= n) r.status = STAT_RANGE;
          else begin
            tr = it.row / d;
            tc = it.col / d;
            lr = it.row % d;
            lc = it.col % d;
            t = tr * MAX_BLOCKS + tc;
            r.tile_row = BSEL_W'(tr);
            r.tile_col = BSEL_W'(tc);
            r.local_row = LROW_W'(lr);
            if (fill[t] >= TILE_CAPACITY) r.status = STAT_FULL;
            else begin
              s = fill[t];
              row_mem[t][s] = LROW_W'(lr);
              fill[t] = PTR_W'(s + 1);
              col_count[t][lc + 1] = col_count[t][lc + 1] + PTR_W'(1);
              r.slot = SLOT_W'(s);
              r.status = STAT_OK;
            end
          end
        end
        MODE_FINAL: begin
          if (done_final) r.status = STAT_FINAL;
          else begin
            for (int tt = 0; tt < NTILES; tt++) begin
              for (int j = 1; j < d; j++) col_count[tt][j] = col_count[tt][j] + col_count[tt][j-1];
              col_count[tt][d] = fill[tt];
            end
            done_final = 1'b1;
            r.status = STAT_OK;
          end
        end
        default: begin
          tr = it.sel_block_row;
          tc = it.sel_block_col;
          t = tr * MAX_BLOCKS + tc;
          r.tile_row = it.sel_block_row;
          r.tile_col = it.sel_block_col;
          if (it.mode == MODE_PTR) begin
            if (tr >= nb || tc >= nb || it.sel_local_col > d) r.status = STAT_RANGE;
            else r.pointer = col_count[t][it.sel_local_col];
          end else begin
            r.slot = it.sel_slot;
            if (tr >= nb || tc >= nb || it.sel_slot >= fill[t]) r.status = STAT_RANGE;
            else r.local_row = row_mem[t][it.sel_slot];
          end
        end
      endcase
      return r;
    endfunction

    function void take_item(item_t it);
      pending_results.push_back(tile_outcome(it));
    endfunction

    function void match_result(scbp_res_t got);
      scbp_res_t want;
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: result with none pending: tr=%0d tc=%0d lr=%0d slot=%0d ptr=%0d st=%0d",
                   $time, got.tile_row, got.tile_col, got.local_row, got.slot, got.pointer,
                   got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got.tile_row !== want.tile_row || got.tile_col !== want.tile_col ||
          got.local_row !== want.local_row || got.slot !== want.slot ||
          got.pointer !== want.pointer || got.status !== want.status) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("%0t: mismatch expected tr=%0d tc=%0d lr=%0d slot=%0d ptr=%0d st=%0d",
                   $time, want.tile_row, want.tile_col, want.local_row, want.slot,
                   want.pointer, want.status);
          $display("%0t:          actual   tr=%0d tc=%0d lr=%0d slot=%0d ptr=%0d st=%0d",
                   $time, got.tile_row, got.tile_col, got.local_row, got.slot,
                   got.pointer, got.status);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  bit   hold_req;
  int   idle_cycles = 0;
  csc_tile_tracker sb;

  scbp_in_if  in_ch();
  scbp_out_if out_ch();
  scbp_cfg_if cfg_ch();

  sparse_csc_block_partition_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= it.mode;
    in_ch.row <= it.row;
    in_ch.col <= it.col;
    in_ch.sel_block_row <= it.sel_block_row;
    in_ch.sel_block_col <= it.sel_block_col;
    in_ch.sel_local_col <= it.sel_local_col;
    in_ch.sel_slot <= it.sel_slot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_item(it);
  endtask

  task automatic send_fields(input logic [MODE_W-1:0] mode, input int row, input int col,
                             input int br, input int bc, input int lc, input int sl);
    item_t it;
    it.mode = mode;
    it.row = COORD_W'(row);
    it.col = COORD_W'(col);
    it.sel_block_row = BSEL_W'(br);
    it.sel_block_col = BSEL_W'(bc);
    it.sel_local_col = LCOL_W'(lc);
    it.sel_slot = SLOT_W'(sl);
    send_item(it);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // both registers are written in one burst while the block is idle
  task automatic set_config(input int nb, input int dim);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_NUM_BLOCKS;
    cfg_ch.data <= CFG_DATA_W'(nb);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(CFG_NUM_BLOCKS, CFG_DATA_W'(nb));
    cfg_ch.index <= CFG_BLOCK_DIM;
    cfg_ch.data <= CFG_DATA_W'(dim);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(CFG_BLOCK_DIM, CFG_DATA_W'(dim));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic item_t random_item(input bit allow_final);
    item_t it;
    int unsigned nb, d, n, t, pick;
    nb = sb.blocks();
    d = sb.dim();
    n = nb * d;
    it.mode = MODE_ENTER;
    it.row = COORD_W'($urandom_range(0, 255));
    it.col = COORD_W'($urandom_range(0, 255));
    it.sel_block_row = BSEL_W'($urandom_range(0, 3));
    it.sel_block_col = BSEL_W'($urandom_range(0, 3));
    it.sel_local_col = LCOL_W'($urandom_range(0, 127));
    it.sel_slot = SLOT_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (allow_final && pick < 6) it.mode = MODE_FINAL;
    else if (pick < 66) begin
      it.mode = MODE_ENTER;
      if ($urandom_range(0, 9) != 0) begin
        it.row = COORD_W'($urandom_range(0, n - 1));
        it.col = COORD_W'($urandom_range(0, n - 1));
      end
    end else if (pick < 83) begin
      it.mode = MODE_PTR;
      if ($urandom_range(0, 7) != 0) begin
        it.sel_block_row = BSEL_W'($urandom_range(0, nb - 1));
        it.sel_block_col = BSEL_W'($urandom_range(0, nb - 1));
        it.sel_local_col = LCOL_W'($urandom_range(0, d));
      end
    end else begin
      it.mode = MODE_ROW;
      if ($urandom_range(0, 7) != 0) begin
        it.sel_block_row = BSEL_W'($urandom_range(0, nb - 1));
        it.sel_block_col = BSEL_W'($urandom_range(0, nb - 1));
        t = it.sel_block_row * MAX_BLOCKS + it.sel_block_col;
        if (sb.fill[t] != 0) it.sel_slot = SLOT_W'($urandom_range(0, sb.fill[t] - 1));
      end
    end
    return it;
  endfunction

  task automatic random_segment(input int nb, input int dim, input int count,
                                input bit allow_final);
    set_config(nb, dim);
    repeat (count) send_item(random_item(allow_final));
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 5);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.match_result('{tile_row: out_ch.tile_row, tile_col: out_ch.tile_col,
                        local_row: out_ch.local_row, slot: out_ch.slot,
                        pointer: out_ch.pointer, status: out_ch.status});
    end
  end

  // no transfer of any kind for too long means a hang
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int tr, tc;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_ENTER;
    in_ch.row <= '0;
    in_ch.col <= '0;
    in_ch.sel_block_row <= '0;
    in_ch.sel_block_col <= '0;
    in_ch.sel_local_col <= '0;
    in_ch.sel_slot <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_NUM_BLOCKS;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: corners of the matrix, reads before finalize
    send_fields(MODE_ENTER, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_ENTER, 255, 255, 0, 0, 0, 0);
    send_fields(MODE_ENTER, 255, 0, 0, 0, 0, 0);
    send_fields(MODE_ENTER, 0, 255, 0, 0, 0, 0);
    send_fields(MODE_ENTER, 170, 85, 0, 0, 0, 0);
    send_fields(MODE_ENTER, 255, 254, 0, 0, 0, 0);
    send_fields(MODE_PTR, 0, 0, 3, 3, 64, 0);
    send_fields(MODE_PTR, 0, 0, 3, 3, 127, 0);
    send_fields(MODE_PTR, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_ROW, 0, 0, 3, 3, 0, 1);
    send_fields(MODE_ROW, 0, 0, 3, 3, 0, 2);
    send_fields(MODE_ROW, 0, 0, 0, 0, 0, 1023);

    // smaller matrix: entries and tiles outside it
    set_config(2, 64);
    send_fields(MODE_ENTER, 200, 10, 0, 0, 0, 0);
    send_fields(MODE_ENTER, 10, 128, 0, 0, 0, 0);
    send_fields(MODE_PTR, 0, 0, 3, 0, 0, 0);
    send_fields(MODE_ROW, 0, 0, 0, 3, 0, 0);

    // zero registers saturate to one tile of side one
    set_config(0, 0);
    send_fields(MODE_ENTER, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_ENTER, 1, 0, 0, 0, 0, 0);
    send_fields(MODE_PTR, 0, 0, 0, 0, 1, 0);
    send_fields(MODE_PTR, 0, 0, 0, 0, 2, 0);
    send_fields(MODE_ROW, 0, 0, 1, 0, 0, 0);

    random_segment(1, 64, 100, 1'b0);
    calm = 1'b1;
    hold_req = 1'b1;
    random_segment(2, 32, 100, 1'b0);
    calm = 1'b0;
    random_segment(4, 1, 100, 1'b0);
    random_segment(3, 21, 100, 1'b0);
    calm = 1'b1;
    random_segment(0, 127, 100, 1'b0);
    calm = 1'b0;
    random_segment(7, 0, 100, 1'b0);
    random_segment($urandom_range(0, 7), $urandom_range(0, 127), 100, 1'b0);

    tr = $urandom_range(0, MAX_BLOCKS - 1);
    tc = $urandom_range(0, MAX_BLOCKS - 1);

    // finalize once, then a second finalize and an entry that are refused, then reads
    set_config(7, 127);
    send_fields(MODE_FINAL, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_FINAL, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_ENTER, 3, 4, 0, 0, 0, 0);
    send_fields(MODE_PTR, 0, 0, tr, tc, MAX_BLOCK_DIM, 0);
    send_fields(MODE_ROW, 0, 0, tr, tc, 0, TILE_CAPACITY - 1);
    random_segment(2, 40, 80, 1'b1);
    calm = 1'b1;
    random_segment(4, 64, 80, 1'b1);

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.bad_results == 0 && sb.pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
